### rtl/clcd_pkg.sv
package clcd_pkg;

   // fixed field widths
   localparam int ColWidth   = 5;
   localparam int CharWidth  = 8;
   localparam int NibWidth   = 4;
   localparam int ByteWidth  = 8;

   // default line length of the display
   localparam int DefaultColumns = 16;

   // microprogram
   localparam int ProgDepth  = 18;
   localparam int PcWidth    = 5;
   localparam int PhaseWidth = 2;

   // entry points
   localparam logic [PcWidth-1:0] EntryInit   = PcWidth'(0);
   localparam logic [PcWidth-1:0] EntryCursor = PcWidth'(14);
   localparam logic [PcWidth-1:0] EntryChar   = PcWidth'(16);

   // strobe phases of one nibble
   localparam logic [PhaseWidth-1:0] PhaseSetup  = PhaseWidth'(0);
   localparam logic [PhaseWidth-1:0] PhaseStrobe = PhaseWidth'(1);
   localparam logic [PhaseWidth-1:0] PhaseHold   = PhaseWidth'(2);

   localparam logic [CharWidth-1:0] CharNewline = 8'h0A;

   typedef enum logic [1:0] {
      SRC_CONST   = 2'd0,
      SRC_CHAR_HI = 2'd1,
      SRC_CHAR_LO = 2'd2
   } nib_src_type;

   typedef struct packed {
      nib_src_type           src;
      logic [NibWidth-1:0]   nib;
      logic                  rs;
      logic                  done;
      logic                  done_if_nl;
   } uword_type;

   // one control word per nibble
   function automatic uword_type prog_word(input logic [PcWidth-1:0] pc);
      uword_type w;
      w = '{src: SRC_CONST, nib: 4'h0, rs: 1'b0, done: 1'b1, done_if_nl: 1'b0};
      case (pc)
         // power-up: three 0x3 nibbles, then 0x2 selects 4-bit mode
         5'd0:  w = '{SRC_CONST, 4'h3, 1'b0, 1'b0, 1'b0};
         5'd1:  w = '{SRC_CONST, 4'h3, 1'b0, 1'b0, 1'b0};
         5'd2:  w = '{SRC_CONST, 4'h3, 1'b0, 1'b0, 1'b0};
         5'd3:  w = '{SRC_CONST, 4'h2, 1'b0, 1'b0, 1'b0};
         // entry mode 0x06
         5'd4:  w = '{SRC_CONST, 4'h0, 1'b0, 1'b0, 1'b0};
         5'd5:  w = '{SRC_CONST, 4'h6, 1'b0, 1'b0, 1'b0};
         // display on, cursor blink 0x0f
         5'd6:  w = '{SRC_CONST, 4'h0, 1'b0, 1'b0, 1'b0};
         5'd7:  w = '{SRC_CONST, 4'hF, 1'b0, 1'b0, 1'b0};
         // cursor shift 0x14
         5'd8:  w = '{SRC_CONST, 4'h1, 1'b0, 1'b0, 1'b0};
         5'd9:  w = '{SRC_CONST, 4'h4, 1'b0, 1'b0, 1'b0};
         // function set 0x28
         5'd10: w = '{SRC_CONST, 4'h2, 1'b0, 1'b0, 1'b0};
         5'd11: w = '{SRC_CONST, 4'h8, 1'b0, 1'b0, 1'b0};
         // clear display 0x01
         5'd12: w = '{SRC_CONST, 4'h0, 1'b0, 1'b0, 1'b0};
         5'd13: w = '{SRC_CONST, 4'h1, 1'b0, 1'b1, 1'b0};
         // cursor to second line 0xc0
         5'd14: w = '{SRC_CONST, 4'hC, 1'b0, 1'b0, 1'b0};
         5'd15: w = '{SRC_CONST, 4'h0, 1'b0, 1'b0, 1'b1};
         // character data
         5'd16: w = '{SRC_CHAR_HI, 4'h0, 1'b1, 1'b0, 1'b0};
         5'd17: w = '{SRC_CHAR_LO, 4'h0, 1'b1, 1'b1, 1'b0};
         default: w = '{SRC_CONST, 4'h0, 1'b0, 1'b1, 1'b0};
      endcase
      return w;
   endfunction

endpackage

### rtl/char_lcd_i2c_text_streamer.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_opcode, req_character, req_first_of_text
// rsp     | out       | rsp_valid, rsp_stall | rsp_expander_byte, rsp_last
//
// one expander word per cycle after the accept cycle while the output is not stalled;
// a character sends its two nibbles, a wrapping character first sends the second-line cursor command;
// a top-row newline sends only that command; a bottom-row newline sends no word
// the microprogram issues one nibble per step, three words per nibble (enable low/high/low)
// a new item is taken once the last word of the previous item sits in the output register
// reset is synchronous, active high; it clears row, column and the sequencer
// a stalled output word holds and stalls the sequencer in place
module char_lcd_i2c_text_streamer #(
   parameter int COLUMNS = clcd_pkg::DefaultColumns
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [clcd_pkg::CharWidth-1:0]  req_character,
   input  logic                            req_first_of_text,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [clcd_pkg::ByteWidth-1:0]  rsp_expander_byte,
   output logic                            rsp_last
);
   import clcd_pkg::*;

   localparam logic [ColWidth-1:0] ColLimit = ColWidth'(COLUMNS);

   // cursor state
   logic                  row_ff, row_in;
   logic [ColWidth-1:0]   col_ff, col_in;

   // sequencer
   logic                  busy_ff, busy_in;
   logic [PcWidth-1:0]    pc_ff, pc_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  is_nl_ff, is_nl_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0]  out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;

   logic                  accept;
   logic                  advance;
   logic                  row_eff;
   logic [ColWidth-1:0]   col_eff;
   logic [ColWidth-1:0]   col_wrap;
   logic                  is_nl;
   logic                  wrap;
   uword_type             uw;
   logic [NibWidth-1:0]   nib;
   logic                  step_end;

   assign req_stall         = busy_ff;
   assign accept            = req_valid && !busy_ff;
   assign advance           = !out_valid_ff || !rsp_stall;
   assign rsp_valid         = out_valid_ff;
   assign rsp_expander_byte = out_byte_ff;
   assign rsp_last          = out_last_ff;

   // control word of the current step
   assign uw = prog_word(pc_ff);

   // start of text clears the cursor before anything else
   assign row_eff = req_first_of_text ? 1'b0 : row_ff;
   assign col_eff = req_first_of_text ? '0 : col_ff;
   assign is_nl   = (req_character == CharNewline);
   assign wrap    = (col_eff >= ColLimit) && !row_eff;
   assign col_wrap = wrap ? '0 : col_eff;

   // nibble source select
   always_comb begin
      unique case (uw.src)
         SRC_CHAR_HI: nib = char_ff[7:4];
         SRC_CHAR_LO: nib = char_ff[3:0];
         default:     nib = uw.nib;
      endcase
   end

   // a step ends either always or only for a newline item
   assign step_end = uw.done || (uw.done_if_nl && is_nl_ff);

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      phase_in     = phase_ff;
      char_in      = char_ff;
      is_nl_in     = is_nl_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (advance) begin
         out_valid_in = 1'b0;
      end

      if (accept) begin
         char_in  = req_character;
         is_nl_in = is_nl;
         phase_in = PhaseSetup;
         row_in   = row_eff;
         col_in   = col_eff;
         if (req_opcode) begin
            busy_in = 1'b1;
            pc_in   = EntryInit;
         end else if (is_nl) begin
            // newline on the bottom row sends nothing
            if (!row_eff) begin
               busy_in = 1'b1;
               pc_in   = EntryCursor;
               row_in  = 1'b1;
               col_in  = '0;
            end
         end else begin
            busy_in = 1'b1;
            pc_in   = wrap ? EntryCursor : EntryChar;
            row_in  = row_eff || wrap;
            // column saturates at the line length
            col_in  = (col_wrap < ColLimit) ? col_wrap + ColWidth'(1) : col_wrap;
         end
      end else if (busy_ff && advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = {nib, 1'b1, (phase_ff == PhaseStrobe), 1'b0, uw.rs};
         out_last_in  = (phase_ff == PhaseHold) && step_end;
         if (phase_ff == PhaseHold) begin
            phase_in = PhaseSetup;
            if (step_end) begin
               busy_in = 1'b0;
            end else begin
               pc_in = pc_ff + PcWidth'(1);
            end
         end else begin
            phase_in = phase_ff + PhaseWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 1'b0;
         col_ff       <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         phase_ff     <= PhaseSetup;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      is_nl_ff    <= is_nl_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

### rtl/clcd_checker.sv
module clcd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_opcode,
   input logic [clcd_pkg::CharWidth-1:0]  req_character,
   input logic                            req_first_of_text,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [clcd_pkg::ByteWidth-1:0]  rsp_expander_byte,
   input logic                            rsp_last
);
   import clcd_pkg::*;

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_expander_byte) && $stable(rsp_last))
      else $error("output word changed under stall");

   // backlight always on, rw always low
   a_fixed_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_expander_byte[3] && !rsp_expander_byte[1])
      else $error("backlight or rw bit wrong");

   // an item never ends on the enable strobe
   a_strobe_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expander_byte[2] |-> !rsp_last)
      else $error("last flagged on enable strobe");

   // mid-item the input stays stalled
   a_busy_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input accepted before item finished");

endmodule

bind char_lcd_i2c_text_streamer clcd_checker u_clcd_checker (.*);

### dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import clcd_pkg::*;

   // opcodes of the request word
   localparam logic OP_PRINT = 1'b0;
   localparam logic OP_INIT  = 1'b1;

   // register select values
   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   // expander bits and lcd commands
   localparam logic [ByteWidth-1:0] BACKLIGHT_BIT = 8'h08;
   localparam logic [ByteWidth-1:0] ENABLE_BIT    = 8'h04;
   localparam logic [ByteWidth-1:0] CURSOR_LINE2  = 8'h80 | 8'h40;
   localparam logic [NibWidth-1:0]  WAKE_NIBBLE   = 4'h3;
   localparam logic [NibWidth-1:0]  FOUR_BIT_NIB  = 4'h2;
   // entry mode, display on, cursor shift, function set, clear
   localparam logic [5*ByteWidth-1:0] INIT_CMDS = {8'h06, 8'h0F, 8'h14, 8'h28, 8'h01};

   localparam int LINE_COLUMNS = DefaultColumns;
   localparam logic [ColWidth-1:0] LINE_LIMIT = ColWidth'(LINE_COLUMNS);
   localparam int IDLE_PERCENT = 28;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [ByteWidth-1:0] exp_byte;
      logic                 last;
   } lcd_word_type;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic                 req_opcode        = OP_PRINT;
   logic [CharWidth-1:0] req_character     = '0;
   logic                 req_first_of_text = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [ByteWidth-1:0] rsp_expander_byte;
   logic                 rsp_last;

   // predicted display cursor
   logic                 lcd_row;
   logic [ColWidth-1:0]  lcd_col;

   // expander words still owed by the block, oldest first
   lcd_word_type         pending_expander_q[$];
   // words of the request being predicted
   lcd_word_type         request_words_q[$];

   int                   mismatches   = 0;
   bit                   steady       = 1'b0;  // no gaps, no stalls
   int                   hold_request = 0;
   int                   hold_left    = 0;

   char_lcd_i2c_text_streamer #(
      .COLUMNS(LINE_COLUMNS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_character    (req_character),
      .req_first_of_text(req_first_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_expander_byte(rsp_expander_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ------------------------------------------------------------------
   // lcd stream prediction
   // ------------------------------------------------------------------

   // one nibble goes out as enable low, high, low
   function void emit_nibble(input logic [NibWidth-1:0] nib, input logic rs);
      logic [ByteWidth-1:0] base;
      base = {nib, 4'b0000} | BACKLIGHT_BIT | {7'b0, rs};
      request_words_q.push_back('{exp_byte: base, last: 1'b0});
      request_words_q.push_back('{exp_byte: base | ENABLE_BIT, last: 1'b0});
      request_words_q.push_back('{exp_byte: base, last: 1'b0});
   endfunction

   // high nibble first
   function void emit_lcd_byte(input logic [ByteWidth-1:0] b, input logic rs);
      emit_nibble(b[7:4], rs);
      emit_nibble(b[3:0], rs);
   endfunction

   function void predict_lcd_words(input logic op, input logic [CharWidth-1:0] ch,
                                   input logic first);
      lcd_word_type w;
      request_words_q.delete();
      if (first) begin
         lcd_row = 1'b0;
         lcd_col = '0;
      end
      if (op == OP_INIT) begin
         // power-up wakeup, then 4-bit mode, then the setup commands; cursor untouched
         for (int k = 0; k < 3; k++) emit_nibble(WAKE_NIBBLE, RS_CMD);
         emit_nibble(FOUR_BIT_NIB, RS_CMD);
         for (int k = 0; k < 5; k++) emit_lcd_byte(INIT_CMDS[(4-k)*8 +: 8], RS_CMD);
      end else if (ch == CharNewline) begin
         // newline on the bottom row is swallowed
         if (lcd_row == 1'b0) begin
            lcd_row = 1'b1;
            lcd_col = '0;
            emit_lcd_byte(CURSOR_LINE2, RS_CMD);
         end
      end else begin
         // full top row wraps to the second line before printing
         if (lcd_col >= LINE_LIMIT && lcd_row == 1'b0) begin
            lcd_row = 1'b1;
            lcd_col = '0;
            emit_lcd_byte(CURSOR_LINE2, RS_CMD);
         end
         emit_lcd_byte(ch, RS_DATA);
         // bottom row saturates
         if (lcd_col < LINE_LIMIT) lcd_col = lcd_col + ColWidth'(1);
      end
      for (int k = 0; k < request_words_q.size(); k++) begin
         w = request_words_q[k];
         w.last = (k == request_words_q.size() - 1);
         pending_expander_q.push_back(w);
      end
   endfunction

   // ------------------------------------------------------------------
   // monitor: check each output word, then predict each accepted request
   // both handshakes sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor_proc
      lcd_word_type w;
      if (reset) begin
         lcd_row = 1'b0;
         lcd_col = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_expander_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected word: byte %02h last %0d", rsp_expander_byte,
                           rsp_last);
            end else begin
               w = pending_expander_q.pop_front();
               if (rsp_expander_byte !== w.exp_byte || rsp_last !== w.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                              w.exp_byte, w.last, rsp_expander_byte, rsp_last);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_lcd_words(req_opcode, req_character, req_first_of_text);
      end
   end

   // ------------------------------------------------------------------
   // receiver: random stalls, or a long hold-off counted here
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------

   // offer one request word and hold it until taken; valid stays high afterwards
   task automatic send_request(input logic op, input logic [CharWidth-1:0] ch,
                               input logic first);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_character     <= ch;
      req_first_of_text <= first;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // stop offering and wait for every owed word
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_expander_q.size() != 0) @(posedge clock);
   endtask

   // random text byte that is not a newline
   function automatic logic [CharWidth-1:0] random_glyph();
      logic [CharWidth-1:0] c;
      c = CharWidth'($urandom_range(255));
      if (c == CharNewline) c = 8'h20;
      return c;
   endfunction

   // one line-structured text: first_of_text, then glyphs with some newlines
   task automatic send_text(input int len);
      logic [CharWidth-1:0] c;
      send_request(OP_PRINT, random_glyph(), 1'b1);
      for (int k = 0; k < len; k++) begin
         c = ($urandom_range(99) < 8) ? CharNewline : CharWidth'($urandom_range(255));
         send_request(OP_PRINT, c, 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // init with and without first_of_text
   task automatic test_init_sequence();
      send_request(OP_INIT, 8'h00, 1'b0);
      send_request(OP_INIT, 8'hFF, 1'b1);
      drain_results();
   endtask

   // zero byte and all ones, plus alternating patterns
   task automatic test_character_extremes();
      send_request(OP_PRINT, 8'h00, 1'b1);
      send_request(OP_PRINT, 8'hFF, 1'b0);
      send_request(OP_PRINT, 8'h55, 1'b0);
      send_request(OP_PRINT, 8'hAA, 1'b0);
      drain_results();
   endtask

   // newline on top row moves the cursor, on the bottom row it does nothing
   task automatic test_newline_handling();
      send_request(OP_PRINT, CharNewline, 1'b1);
      send_request(OP_PRINT, CharNewline, 1'b0);
      send_request(OP_PRINT, 8'h41, 1'b0);
      send_request(OP_PRINT, CharNewline, 1'b0);
      drain_results();
   endtask

   // a full top row, then one more character wraps
   task automatic test_line_wrap();
      for (int k = 0; k <= LINE_COLUMNS; k++)
         send_request(OP_PRINT, CharWidth'(8'h30 + k), (k == 0));
      drain_results();
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      hold_request = 300;
      steady = 1'b1;
      for (int k = 0; k < 24; k++)
         send_request(OP_PRINT, random_glyph(), (k == 0));
      steady = 1'b0;
      drain_results();
   endtask

   // a stretch with no gaps and no stalls on either side
   task automatic test_back_to_back();
      steady = 1'b1;
      send_request(OP_INIT, 8'h00, 1'b1);
      send_text(LINE_COLUMNS + 4);
      send_text(2 * LINE_COLUMNS + 6);
      steady = 1'b0;
      drain_results();
   endtask

   // mostly texts, some inits, some random words
   task automatic test_random_texts(input int n_words);
      int sent;
      int len;
      int pick;
      sent = 0;
      while (sent < n_words) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            len = $urandom_range(40);
            send_text(len);
            sent += len + 1;
         end else if (pick < 86) begin
            send_request(OP_INIT, CharWidth'($urandom_range(255)), 1'($urandom_range(1)));
            sent++;
         end else begin
            send_request(1'($urandom_range(99) < 20), CharWidth'($urandom_range(255)),
                         1'($urandom_range(1)));
            sent++;
         end
         // now and then wait for the stream to empty
         if ($urandom_range(99) < 10) drain_results();
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_init_sequence();
      test_character_extremes();
      test_newline_handling();
      test_line_wrap();
      test_backpressure();
      test_back_to_back();
      test_random_texts(250);

      // let a trailing swallowed newline or stray word show up
      drain_results();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_expander_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
